// ----- design/tmpd_pkg.sv -----
`timescale 1ns / 1ps

package tmpd_pkg;

  localparam int unsigned NumRegs   = 6;
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned MsWidth   = 16;
  localparam int unsigned TimeWidth = 32;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_DIR   = 2'd1,
    OP_SET_SPEED = 2'd2,
    OP_STOP      = 2'd3
  } op_e;

  localparam logic [1:0] PHASE_OFF  = 2'd0;
  localparam logic [1:0] PHASE_HIGH = 2'd1;
  localparam logic [1:0] PHASE_LOW  = 2'd2;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd2;
  localparam logic [1:0] DIR_BAD  = 2'd3;

  localparam logic [1:0] SPEED_IDLE = 2'd0;
  localparam logic [1:0] SPEED_FINE = 2'd1;
  localparam logic [1:0] SPEED_SLOW = 2'd2;
  localparam logic [1:0] SPEED_FAST = 2'd3;

  localparam logic [2:0] REG_FINE_ON  = 3'd0;
  localparam logic [2:0] REG_FINE_OFF = 3'd1;
  localparam logic [2:0] REG_SLOW_ON  = 3'd2;
  localparam logic [2:0] REG_SLOW_OFF = 3'd3;
  localparam logic [2:0] REG_FAST_ON  = 3'd4;
  localparam logic [2:0] REG_FAST_OFF = 3'd5;

  typedef struct packed {
    logic [MsWidth-1:0] fine_on;
    logic [MsWidth-1:0] fine_off;
    logic [MsWidth-1:0] slow_on;
    logic [MsWidth-1:0] slow_off;
    logic [MsWidth-1:0] fast_on;
    logic [MsWidth-1:0] fast_off;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           operation;
    logic [1:0]           arg_value;
    logic [TimeWidth-1:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic       up_drive;
    logic       down_drive;
    logic       led_level;
    logic [1:0] phase_now;
    logic [1:0] direction_now;
    logic [1:0] speed_now;
  } result_t;

endpackage

// ----- design/tmpd_cfg_regs.sv -----
`timescale 1ns / 1ps

module tmpd_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tmpd_pkg::AddrWidth-1:0]      paddr,
  input  logic [tmpd_pkg::DataWidth-1:0]      pwdata,
  output logic [tmpd_pkg::DataWidth-1:0]      prdata,
  output logic                                pready,
  output tmpd_pkg::cfg_t                      cfg_o
);

  tmpd_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     idx;
  logic [tmpd_pkg::MsWidth-1:0] wval;
  logic [tmpd_pkg::MsWidth-1:0] rval;

  assign idx    = paddr[4:2];
  assign wval   = pwdata[tmpd_pkg::MsWidth-1:0];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (idx)
        tmpd_pkg::REG_FINE_ON:  cfg_d.fine_on  = wval;
        tmpd_pkg::REG_FINE_OFF: cfg_d.fine_off = wval;
        tmpd_pkg::REG_SLOW_ON:  cfg_d.slow_on  = wval;
        tmpd_pkg::REG_SLOW_OFF: cfg_d.slow_off = wval;
        tmpd_pkg::REG_FAST_ON:  cfg_d.fast_on  = wval;
        tmpd_pkg::REG_FAST_OFF: cfg_d.fast_off = wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tmpd_pkg::REG_FINE_ON:  rval = cfg_q.fine_on;
      tmpd_pkg::REG_FINE_OFF: rval = cfg_q.fine_off;
      tmpd_pkg::REG_SLOW_ON:  rval = cfg_q.slow_on;
      tmpd_pkg::REG_SLOW_OFF: rval = cfg_q.slow_off;
      tmpd_pkg::REG_FAST_ON:  rval = cfg_q.fast_on;
      tmpd_pkg::REG_FAST_OFF: rval = cfg_q.fast_off;
      default:                rval = '0;
    endcase
  end

  assign prdata = {{(tmpd_pkg::DataWidth - tmpd_pkg::MsWidth){1'b0}}, rval};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- design/tmpd_core.sv -----
`timescale 1ns / 1ps

module tmpd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  tmpd_pkg::cmd_t    cmd_i,
  input  tmpd_pkg::cfg_t    cfg_i,
  output tmpd_pkg::result_t res_o
);

  logic [1:0]                     dir_q, dir_d;
  logic [1:0]                     speed_q, speed_d;
  logic [1:0]                     phase_q, phase_d;
  logic                           is_down_q, is_down_d;
  logic [tmpd_pkg::MsWidth-1:0]   on_q, on_d;
  logic [tmpd_pkg::MsWidth-1:0]   off_q, off_d;
  logic [tmpd_pkg::TimeWidth-1:0] start_q, start_d;
  logic                           start_vld_q, start_vld_d;
  logic                           up_q, up_d;
  logic                           down_q, down_d;
  logic                           led_q, led_d;

  logic                           want_down;
  logic [tmpd_pkg::MsWidth-1:0]   sel_on, sel_off;
  logic [tmpd_pkg::TimeWidth-1:0] elapsed;

  assign want_down = (dir_q == tmpd_pkg::DIR_DOWN);

  always_comb begin
    unique case (speed_q)
      tmpd_pkg::SPEED_FINE: begin
        sel_on  = cfg_i.fine_on;
        sel_off = cfg_i.fine_off;
      end
      tmpd_pkg::SPEED_SLOW: begin
        sel_on  = cfg_i.slow_on;
        sel_off = cfg_i.slow_off;
      end
      default: begin
        sel_on  = cfg_i.fast_on;
        sel_off = cfg_i.fast_off;
      end
    endcase
  end

  always_comb begin
    dir_d       = dir_q;
    speed_d     = speed_q;
    phase_d     = phase_q;
    is_down_d   = is_down_q;
    on_d        = on_q;
    off_d       = off_q;
    start_d     = start_q;
    start_vld_d = start_vld_q;
    up_d        = up_q;
    down_d      = down_q;
    led_d       = led_q;
    elapsed     = '0;

    unique case (tmpd_pkg::op_e'(cmd_i.operation))
      tmpd_pkg::OP_TICK: begin
        if (speed_q == tmpd_pkg::SPEED_IDLE) begin
          up_d    = 1'b0;
          down_d  = 1'b0;
          led_d   = 1'b1;
          phase_d = tmpd_pkg::PHASE_OFF;
        end else if (phase_q == tmpd_pkg::PHASE_OFF || want_down != is_down_q ||
                     sel_on != on_q || sel_off != off_q) begin
          up_d        = 1'b0;
          down_d      = 1'b0;
          led_d       = 1'b1;
          is_down_d   = want_down;
          on_d        = sel_on;
          off_d       = sel_off;
          phase_d     = tmpd_pkg::PHASE_HIGH;
          start_vld_d = 1'b0;
        end

        if (phase_d != tmpd_pkg::PHASE_OFF) begin
          if (!start_vld_d) begin
            start_d     = cmd_i.now_ms;
            start_vld_d = 1'b1;
          end
          elapsed = cmd_i.now_ms - start_d;
          if (phase_d == tmpd_pkg::PHASE_HIGH) begin
            led_d = 1'b0;
            if (is_down_d) down_d = 1'b1;
            else           up_d   = 1'b1;
            if (elapsed >= {{(tmpd_pkg::TimeWidth - tmpd_pkg::MsWidth){1'b0}}, on_d}) begin
              if (off_d != '0) begin
                up_d    = 1'b0;
                down_d  = 1'b0;
                led_d   = 1'b1;
                phase_d = tmpd_pkg::PHASE_LOW;
              end
              start_vld_d = 1'b0;
            end
          end else begin
            led_d = 1'b1;
            if (is_down_d) down_d = 1'b0;
            else           up_d   = 1'b0;
            if (elapsed >= {{(tmpd_pkg::TimeWidth - tmpd_pkg::MsWidth){1'b0}}, off_d}) begin
              up_d        = 1'b0;
              down_d      = 1'b0;
              led_d       = 1'b1;
              phase_d     = tmpd_pkg::PHASE_HIGH;
              start_vld_d = 1'b0;
            end
          end
        end
      end
      tmpd_pkg::OP_SET_DIR: begin
        up_d        = 1'b0;
        down_d      = 1'b0;
        led_d       = 1'b1;
        phase_d     = tmpd_pkg::PHASE_OFF;
        start_vld_d = 1'b0;
        dir_d       = (cmd_i.arg_value == tmpd_pkg::DIR_BAD) ? tmpd_pkg::DIR_NONE
                                                             : cmd_i.arg_value;
      end
      tmpd_pkg::OP_SET_SPEED: begin
        speed_d = cmd_i.arg_value;
      end
      tmpd_pkg::OP_STOP: begin
        up_d    = 1'b0;
        down_d  = 1'b0;
        led_d   = 1'b1;
        speed_d = tmpd_pkg::SPEED_IDLE;
        dir_d   = tmpd_pkg::DIR_NONE;
        phase_d = tmpd_pkg::PHASE_OFF;
      end
      default: ;
    endcase
  end

  assign res_o.up_drive      = up_d;
  assign res_o.down_drive    = down_d;
  assign res_o.led_level     = led_d;
  assign res_o.phase_now     = phase_d;
  assign res_o.direction_now = dir_d;
  assign res_o.speed_now     = speed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= tmpd_pkg::DIR_NONE;
      speed_q     <= tmpd_pkg::SPEED_IDLE;
      phase_q     <= tmpd_pkg::PHASE_OFF;
      is_down_q   <= 1'b0;
      on_q        <= '0;
      off_q       <= '0;
      start_q     <= '0;
      start_vld_q <= 1'b0;
      up_q        <= 1'b0;
      down_q      <= 1'b0;
      led_q       <= 1'b1;
    end else if (step_i) begin
      dir_q       <= dir_d;
      speed_q     <= speed_d;
      phase_q     <= phase_d;
      is_down_q   <= is_down_d;
      on_q        <= on_d;
      off_q       <= off_d;
      start_q     <= start_d;
      start_vld_q <= start_vld_d;
      up_q        <= up_d;
      down_q      <= down_d;
      led_q       <= led_d;
    end
  end

endmodule

// ----- design/tmpd_out_buf.sv -----
`timescale 1ns / 1ps

module tmpd_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tmpd_pkg::result_t data_i,
  output logic              full_o,
  output logic              pop_o,
  output logic              valid_o,
  input  logic              stall_i,
  output tmpd_pkg::result_t data_o
);

  tmpd_pkg::result_t mem_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign pop_o   = valid_o && !stall_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_o  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_o};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- design/tuning_motor_pulse_driver_unit.sv -----
`timescale 1ns / 1ps
// Tuning motor pulse driver.
// Command channel: in_valid_i / in_stall_o with operation_i, arg_value_i and
// now_ms_i. A transfer takes place at a rising edge with valid high and stall
// low. Each command yields exactly one result on the out_valid_o /
// out_stall_i channel: pin levels, pulse phase, direction and speed.
// Timing registers sit on the APB port (byte address 4*i, 16 bits used);
// write them only while no command is in flight.
// A command is registered at its transfer, evaluated against the motor
// state once the result buffer has room or is being read, and then
// written to a two-entry result buffer, which offers its result.
// Throughput: one command per cycle while the receiver takes results.
// When the receiver stalls the buffer fills; after two held results plus one
// in the input register, in_stall_o rises until results are taken again.
// Reset: pins low, indicator high, phase disabled, speed idle, direction
// none, all timing registers zero, no results pending.
module tuning_motor_pulse_driver_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         operation_i,
  input  logic [1:0]                         arg_value_i,
  input  logic [tmpd_pkg::TimeWidth-1:0]     now_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               up_drive_o,
  output logic                               down_drive_o,
  output logic                               led_level_o,
  output logic [1:0]                         phase_now_o,
  output logic [1:0]                         direction_now_o,
  output logic [1:0]                         speed_now_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tmpd_pkg::AddrWidth-1:0]     paddr,
  input  logic [tmpd_pkg::DataWidth-1:0]     pwdata,
  output logic [tmpd_pkg::DataWidth-1:0]     prdata,
  output logic                               pready
);

  tmpd_pkg::cfg_t    cfg;
  tmpd_pkg::cmd_t    cmd_q;
  tmpd_pkg::result_t res;
  tmpd_pkg::result_t res_out;
  logic              cmd_vld_q;
  logic              advance;
  logic              in_take;
  logic              buf_full;
  logic              buf_pop;

  assign advance    = cmd_vld_q && (!buf_full || buf_pop);
  assign in_stall_o = cmd_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
    end else if (in_take || advance) begin
      cmd_vld_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q.operation <= operation_i;
      cmd_q.arg_value <= arg_value_i;
      cmd_q.now_ms    <= now_ms_i;
    end
  end

  tmpd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tmpd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cmd_i  (cmd_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  tmpd_out_buf u_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (advance),
    .data_i  (res),
    .full_o  (buf_full),
    .pop_o   (buf_pop),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_out)
  );

  assign up_drive_o      = res_out.up_drive;
  assign down_drive_o    = res_out.down_drive;
  assign led_level_o     = res_out.led_level;
  assign phase_now_o     = res_out.phase_now;
  assign direction_now_o = res_out.direction_now;
  assign speed_now_o     = res_out.speed_now;

endmodule
